@@ hw/rtl/fnwp_pkg.sv @@
// Package for the nearest-waypoint Frenet projection core.
// Holds opcodes, status codes, the controller state type and CORDIC constants.
// No dependencies.
package fnwp_pkg;

    // Input item opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Result item status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Angle constants, Q16
    localparam logic signed [21:0] Q_PI      = 22'sd205887;
    localparam logic signed [21:0] Q_HALF_PI = 22'sd102944;
    localparam logic signed [21:0] Q_TWO_PI  = 22'sd411775;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [17:0] TAN_MAX = 18'sd131071;
    localparam logic signed [17:0] TAN_MIN = -18'sd131072;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,     // read previous waypoint
        S_APP_SQ,     // square dx, dy
        S_APP_SQRT,   // bit-serial square root
        S_APP_CORD,   // CORDIC iterations
        S_APP_WR,     // write entry
        S_Q_SCAN,     // distance scan
        S_Q_DRAIN,    // finish scan pipeline
        S_Q_RD,       // read best entry
        S_Q_MUL,      // projection products
        S_Q_SUM,      // sum and round
        S_OUT         // hold result
    } t_state;

    // atan(2^-i) in Q16
    function automatic logic signed [21:0] atan_lut(input logic [3:0] i);
        case (i)
            4'd0:    atan_lut = 22'sd51472;
            4'd1:    atan_lut = 22'sd30386;
            4'd2:    atan_lut = 22'sd16055;
            4'd3:    atan_lut = 22'sd8150;
            4'd4:    atan_lut = 22'sd4091;
            4'd5:    atan_lut = 22'sd2047;
            4'd6:    atan_lut = 22'sd1024;
            4'd7:    atan_lut = 22'sd512;
            4'd8:    atan_lut = 22'sd256;
            4'd9:    atan_lut = 22'sd128;
            4'd10:   atan_lut = 22'sd64;
            4'd11:   atan_lut = 22'sd32;
            4'd12:   atan_lut = 22'sd16;
            4'd13:   atan_lut = 22'sd8;
            4'd14:   atan_lut = 22'sd4;
            default: atan_lut = 22'sd2;
        endcase
    endfunction

endpackage

@@ hw/rtl/frenet_nearest_waypoint_projection_core.sv @@
// Nearest-waypoint Cartesian-to-Frenet projection core, top level.
// Depends on fnwp_pkg.
//
// Items are handled one at a time. Clear, no-op, an append to a full table and a
// query on an empty table go straight to the output register. An append does one
// memory read of the previous waypoint, the squares, a 32-step bit-serial square
// root, 16 CORDIC iterations and the table write; the first waypoint skips the read,
// the squares and the square root. A query scan reads one waypoint per cycle from the
// tables through a two-stage distance pipeline, then reads the nearest entry and runs
// a short product/round tail. A result sits in an output register; the next item is
// taken once that result is accepted. No clearing pass is needed after reset.
module frenet_nearest_waypoint_projection_core #(
    parameter int MAX_WAYPOINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] op, [33:2] x_coord, [65:34] y_coord, [85:66] heading, [87:86] zero
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [11:2] waypoint_index, [43:12] path_distance,
    // [75:44] lateral_offset, [79:76] zero
    output logic [79:0] m_axis_tdata
);
    import fnwp_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_WAYPOINTS);

    // Tables
    logic signed [31:0] mem_x   [MAX_WAYPOINTS];
    logic signed [31:0] mem_y   [MAX_WAYPOINTS];
    logic signed [17:0] mem_cos [MAX_WAYPOINTS];
    logic signed [17:0] mem_sin [MAX_WAYPOINTS];
    logic signed [31:0] mem_arc [MAX_WAYPOINTS];

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic signed [31:0] r_px, r_py;
    logic signed [21:0] r_h;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic signed [31:0] rd_x, rd_y, rd_arc;
    logic signed [17:0] rd_cos, rd_sin;

    logic [CW-1:0] r_scan;       // address issued
    logic          r_v1;         // read data valid
    logic [AW-1:0] r_i1;
    logic          r_v2;
    logic [AW-1:0] r_i2;
    logic [63:0]   r_a2, r_b2;
    logic [64:0]   r_best;
    logic [AW-1:0] r_best_i;
    logic          r_have;

    logic [63:0]   r_rad;        // sqrt remainder source
    logic [32:0]   r_root;
    logic [65:0]   r_rem;
    logic [5:0]    r_cnt;
    logic          r_big;
    logic signed [31:0] r_prev_arc;
    logic signed [20:0] r_cx, r_cy;
    logic          r_neg;

    logic signed [63:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [31:0] r_arc_b;

    logic [1:0]  r_st;
    logic [9:0]  r_idx;
    logic signed [31:0] r_s, r_d;

    logic acc_in;
    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_d, r_s, r_idx, r_st};

    function automatic logic signed [17:0] clamp(input logic signed [20:0] v);
        if (v > 21'(TAN_MAX))      clamp = TAN_MAX;
        else if (v < 21'(TAN_MIN)) clamp = TAN_MIN;
        else                       clamp = v[17:0];
    endfunction

    // Arc length of the new waypoint
    logic signed [31:0] arc_new;
    logic signed [33:0] arc_sum;
    assign arc_sum = 34'(r_prev_arc) + (r_big ? 34'sd2147483647 : 34'(r_root[31:0]));
    always_comb begin
        if (r_count == '0)                 arc_new = '0;
        else if (arc_sum > 34'sd2147483647) arc_new = 32'sh7fffffff;
        else                                arc_new = arc_sum[31:0];
    end

    // Memory read port and write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            rd_x   <= mem_x[rd_addr];
            rd_y   <= mem_y[rd_addr];
            rd_cos <= mem_cos[rd_addr];
            rd_sin <= mem_sin[rd_addr];
            rd_arc <= mem_arc[rd_addr];
        end
        if (r_state == S_APP_WR) begin
            mem_x[r_count[AW-1:0]]   <= r_px;
            mem_y[r_count[AW-1:0]]   <= r_py;
            mem_cos[r_count[AW-1:0]] <= clamp(r_neg ? -r_cx : r_cx);
            mem_sin[r_count[AW-1:0]] <= clamp(r_neg ? -r_cy : r_cy);
            mem_arc[r_count[AW-1:0]] <= arc_new;
        end
    end

    // Read address select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            S_APP_RD: begin
                rd_en = 1'b1;
                rd_addr = AW'(r_count - 1'b1);
            end
            S_Q_SCAN: begin
                rd_en = 1'b1;
                rd_addr = r_scan[AW-1:0];
            end
            S_Q_RD: begin
                rd_en = 1'b1;
                rd_addr = r_best_i;
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc_in) begin
                case (s_axis_tdata[1:0])
                    OP_APPEND: n_state = (r_count >= MAX_CNT) ? S_OUT :
                                         (r_count == '0) ? S_APP_CORD : S_APP_RD;
                    OP_QUERY:  n_state = (r_count == '0) ? S_OUT : S_Q_SCAN;
                    default:   n_state = S_OUT;
                endcase
            end
            S_APP_RD:   n_state = S_APP_SQ;
            S_APP_SQ:   n_state = S_APP_SQRT;
            S_APP_SQRT: if (r_cnt == 6'd0) n_state = S_APP_CORD;
            S_APP_CORD: if (r_cnt == 6'd15) n_state = S_APP_WR;
            S_APP_WR:   n_state = S_OUT;
            S_Q_SCAN:   if (r_scan == r_count - 1'b1) n_state = S_Q_DRAIN;
            S_Q_DRAIN:  if (!r_v1 && !r_v2) n_state = S_Q_RD;
            S_Q_RD:     n_state = S_Q_MUL;
            S_Q_MUL:    n_state = S_Q_SUM;
            S_Q_SUM:    n_state = S_OUT;
            S_OUT:      if (m_axis_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1 <= (r_state == S_Q_SCAN);
            r_v2 <= r_v1;
            if (acc_in && s_axis_tdata[1:0] == OP_CLEAR) r_count <= '0;
            if (r_state == S_APP_WR) r_count <= r_count + 1'b1;
        end
    end

    // Heading reduction
    function automatic logic signed [21:0] wrap(input logic signed [21:0] h);
        logic signed [21:0] v;
        v = h;
        if (v > Q_PI)  v = v - Q_TWO_PI;
        if (v > Q_PI)  v = v - Q_TWO_PI;
        if (v < -Q_PI) v = v + Q_TWO_PI;
        if (v < -Q_PI) v = v + Q_TWO_PI;
        wrap = v;
    endfunction

    logic signed [21:0] h_w;
    assign h_w = wrap(22'(signed'(s_axis_tdata[85:66])));

    // Scan datapath: distance squares then compare
    logic signed [32:0] sdx, sdy;
    logic [32:0] adx, ady;
    assign sdx = 33'(r_px) - 33'(rd_x);
    assign sdy = 33'(r_py) - 33'(rd_y);
    assign adx = sdx[32] ? 33'(-sdx) : sdx;
    assign ady = sdy[32] ? 33'(-sdy) : sdy;
    logic [64:0] dist_sq;
    assign dist_sq = 65'(r_a2) + 65'(r_b2);

    // CORDIC step
    logic signed [20:0] cx_sh, cy_sh;
    assign cx_sh = r_cx >>> r_cnt[3:0];
    assign cy_sh = r_cy >>> r_cnt[3:0];

    // Square root step (radicand in r_rad, two bits per step)
    logic [65:0] trial, rem_sh;
    assign rem_sh = {r_rem[63:0], r_rad[63:62]};
    assign trial  = rem_sh - {31'd0, r_root, 2'b01};

    // Projection rounding
    logic signed [65:0] along_q, lat_q;
    logic signed [49:0] along, lat;
    logic signed [50:0] s_full;
    assign along_q = 66'(r_m0) + 66'(r_m1) + 66'sd32768;
    assign lat_q   = 66'(r_m2) - 66'(r_m3) + 66'sd32768;
    assign along   = along_q[65:16];
    assign lat     = lat_q[65:16];
    assign s_full  = 51'(r_arc_b) + 51'(along);

    function automatic logic signed [31:0] sat(input logic signed [50:0] v);
        if (v > 51'sd2147483647)       sat = 32'sh7fffffff;
        else if (v < -51'sd2147483648) sat = 32'sh80000000;
        else                           sat = v[31:0];
    endfunction

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (acc_in) begin
                r_px <= s_axis_tdata[33:2];
                r_py <= s_axis_tdata[65:34];
                r_scan <= '0;
                r_have <= 1'b0;
                r_cnt <= '0;
                r_cx <= 21'(CORDIC_GAIN);
                r_cy <= '0;
                r_prev_arc <= '0;
                if (h_w > Q_HALF_PI) begin
                    r_h <= h_w - Q_PI;  r_neg <= 1'b1;
                end else if (h_w < -Q_HALF_PI) begin
                    r_h <= h_w + Q_PI;  r_neg <= 1'b1;
                end else begin
                    r_h <= h_w;         r_neg <= 1'b0;
                end
                r_idx <= '0; r_s <= '0; r_d <= '0;
                if (s_axis_tdata[1:0] == OP_APPEND && r_count >= MAX_CNT) r_st <= ST_FULL;
                else if (s_axis_tdata[1:0] == OP_QUERY && r_count == '0) r_st <= ST_EMPTY;
                else r_st <= ST_OK;
            end
            S_APP_SQ: begin
                r_big <= adx[32] || ady[32] || adx[31] || ady[31];
                r_rad <= 64'(adx[31:0]) * 64'(adx[31:0]) + 64'(ady[31:0]) * 64'(ady[31:0]);
                r_prev_arc <= rd_arc;
                r_rem <= '0;
                r_root <= '0;
                r_cnt <= 6'd31;
            end
            S_APP_SQRT: begin
                r_rad <= {r_rad[61:0], 2'b00};
                if (!trial[65]) begin
                    r_rem <= trial; r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem <= rem_sh; r_root <= {r_root[31:0], 1'b0};
                end
                if (r_cnt == 6'd0) r_cnt <= '0;
                else r_cnt <= r_cnt - 1'b1;
            end
            S_APP_CORD: begin
                if (!r_h[21]) begin
                    r_cx <= r_cx - cy_sh; r_cy <= r_cy + cx_sh;
                    r_h <= r_h - atan_lut(r_cnt[3:0]);
                end else begin
                    r_cx <= r_cx + cy_sh; r_cy <= r_cy - cx_sh;
                    r_h <= r_h + atan_lut(r_cnt[3:0]);
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_APP_WR: begin
                r_idx <= 10'(r_count);
                r_s <= arc_new;
            end
            S_Q_SCAN, S_Q_DRAIN: begin
                if (r_state == S_Q_SCAN) r_scan <= r_scan + 1'b1;
                r_i1 <= r_scan[AW-1:0];
                r_i2 <= r_i1;
                // distance magnitudes stay below 2^32, so 32-bit squares are exact
                if (r_v1) begin
                    r_a2 <= 64'(adx[31:0]) * 64'(adx[31:0]);
                    r_b2 <= 64'(ady[31:0]) * 64'(ady[31:0]);
                end
                if (r_v2 && (!r_have || dist_sq < r_best)) begin
                    r_best <= dist_sq; r_best_i <= r_i2; r_have <= 1'b1;
                end
            end
            S_Q_MUL: begin
                r_m0 <= 64'(sdx) * 64'(rd_cos);
                r_m1 <= 64'(sdy) * 64'(rd_sin);
                r_m2 <= 64'(sdy) * 64'(rd_cos);
                r_m3 <= 64'(sdx) * 64'(rd_sin);
                r_arc_b <= rd_arc;
            end
            S_Q_SUM: begin
                r_idx <= 10'(r_best_i);
                r_s <= sat(s_full);
                r_d <= sat(51'(lat));
            end
            default: ;
        endcase
    end

endmodule
